[rtl/text_console_cursor_engine_defines.svh]
// Assertion macros for the console engine checker.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TCCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tcce_pkg.sv]
`default_nettype none

package tcce_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int NUM_SCREENS = 2;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int MEM_DEPTH = NUM_SCREENS * CELLS;
  localparam int COL_W     = $clog2(COLUMNS + 1);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int SCR_W     = (NUM_SCREENS > 1) ? $clog2(NUM_SCREENS) : 1;
  localparam int OFF_W     = $clog2(CELLS);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int CELL_W    = 16;

  localparam logic [7:0] BLANK_CODE   = 8'd32;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [2:0] REQ_PRINT  = 3'd0;
  localparam logic [2:0] REQ_DELETE = 3'd1;
  localparam logic [2:0] REQ_CLEAR  = 3'd2;
  localparam logic [2:0] REQ_SWITCH = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR1 = CFG_IDX_W'(1);

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  char_code;
    logic        screen_sel;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_index;
    logic [7:0]  cell_code;
    logic [7:0]  cell_color;
  } out_item_t;

  // operands for the shared address unit
  typedef struct packed {
    logic [SCR_W-1:0] scr;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [OFF_W-1:0] off;
    logic             use_rc;
  } addr_req_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] wdata;
  } mem_op_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] code,
                                                  input logic [SCR_W-1:0] scr,
                                                  input logic [7:0] c0,
                                                  input logic [7:0] c1);
    return {(scr == '0) ? c0 : c1, code};
  endfunction

  function automatic logic [10:0] cursor_lin(input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] col);
    logic [31:0] v;
    v = 32'(row) * 32'(COLUMNS) + 32'(col);
    return v[10:0];
  endfunction

endpackage

`default_nettype wire

[rtl/text_console_cursor_engine.sv]
`default_nettype none

// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   in_item_i  (in_item_t)
// out      out  out_valid_o / out_ready_i out_item_o (out_item_t)
// cfg      in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Print, delete, switch and read go through ST_DISPATCH to ST_DONE. A scroll copies
// the rows up and blanks the last row, a clear blanks the whole screen;
// every cell access goes through the single port of the cell RAM.
// After reset a clearing pass zeroes the RAM with in_ready_o low;
// cfg writes are taken at all times.
// A result waits in the output register while the next beat is accepted.

module text_console_cursor_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  tcce_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output tcce_pkg::out_item_t              out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]                       cfg_data_i
);

  import tcce_pkg::*;

  logic [7:0]        color0_q;
  logic [7:0]        color1_q;
  logic              out_valid_q;
  out_item_t         out_item_q;
  addr_req_t         areq;
  mem_op_t           mop;
  logic [AW-1:0]     addr;
  logic [CELL_W-1:0] rdata;
  logic              res_valid;
  out_item_t         res;
  logic              res_take;

  assign cfg_ready_o = 1'b1;
  assign res_take    = res_valid && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color0_q    <= '0;
      color1_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_COLOR0: color0_q <= cfg_data_i;
          CFG_COLOR1: color1_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_item_q <= res;
    end
  end

  tcce_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .color0_i    (color0_q),
    .color1_i    (color1_q),
    .areq_o      (areq),
    .mop_o       (mop),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  tcce_addr_unit u_addr (
    .req_i  (areq),
    .addr_o (addr)
  );

  tcce_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (CELL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mop.we),
    .addr_i  (addr),
    .wdata_i (mop.wdata),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

[rtl/tcce_ram.sv]
`default_nettype none

module tcce_ram #(
  parameter int DEPTH = 4000,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/tcce_addr_unit.sv]
`default_nettype none

module tcce_addr_unit (
  input  tcce_pkg::addr_req_t     req_i,
  output logic [tcce_pkg::AW-1:0] addr_o
);

  import tcce_pkg::*;

  logic [31:0] rc;
  logic [31:0] off;
  logic [31:0] lin;

  always_comb begin
    rc  = 32'(req_i.row) * 32'(COLUMNS) + 32'(req_i.col);
    off = req_i.use_rc ? rc : 32'(req_i.off);
    lin = 32'(req_i.scr) * 32'(CELLS) + off;
  end

  assign addr_o = lin[AW-1:0];

endmodule

`default_nettype wire

[rtl/tcce_seq.sv]
`default_nettype none

module tcce_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tcce_pkg::in_item_t    in_item_i,
  input  logic [7:0]            color0_i,
  input  logic [7:0]            color1_i,
  output tcce_pkg::addr_req_t   areq_o,
  output tcce_pkg::mem_op_t     mop_o,
  input  logic [tcce_pkg::CELL_W-1:0] rdata_i,
  output logic                  res_valid_o,
  output tcce_pkg::out_item_t   res_o,
  input  logic                  res_take_i
);

  import tcce_pkg::*;

  localparam logic [3:0] ST_INIT     = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DISPATCH = 4'd2;
  localparam logic [3:0] ST_NL       = 4'd3;
  localparam logic [3:0] ST_SC_RD    = 4'd4;
  localparam logic [3:0] ST_SC_WR    = 4'd5;
  localparam logic [3:0] ST_BLANK    = 4'd6;
  localparam logic [3:0] ST_WR_CHAR  = 4'd7;
  localparam logic [3:0] ST_DEL_WR   = 4'd8;
  localparam logic [3:0] ST_RD_WAIT  = 4'd9;
  localparam logic [3:0] ST_DONE     = 4'd10;

  localparam logic [OFF_W-1:0] PTR_LAST   = OFF_W'(CELLS - 1);
  localparam logic [OFF_W-1:0] SCROLL_END = OFF_W'(COLUMNS * (ROWS - 1) - 1);
  localparam logic [SCR_W-1:0] SCR_LAST   = SCR_W'(NUM_SCREENS - 1);

  logic [3:0]       state_q, state_d;
  logic [SCR_W-1:0] wscr_q, wscr_d;
  logic [SCR_W-1:0] cur_scr_q, cur_scr_d;
  logic [OFF_W-1:0] ptr_q, ptr_d;
  logic [COL_W-1:0] cur_col_q [NUM_SCREENS];
  logic [COL_W-1:0] cur_col_d [NUM_SCREENS];
  logic [ROW_W-1:0] cur_row_q [NUM_SCREENS];
  logic [ROW_W-1:0] cur_row_d [NUM_SCREENS];
  in_item_t         req_q, req_d;
  logic             after_nl_q, after_nl_d;
  logic             clr_mode_q, clr_mode_d;
  logic [7:0]       rd_code_q, rd_code_d;
  logic [7:0]       rd_color_q, rd_color_d;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [31:0]      idx32;
  logic             sel_ok;

  assign col    = cur_col_q[wscr_q];
  assign row    = cur_row_q[wscr_q];
  assign idx32  = 32'(req_q.cell_index);
  assign sel_ok = 32'(req_q.screen_sel) < 32'(NUM_SCREENS);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    res_o.cursor_index = cursor_lin(row, col);
    res_o.cell_code    = rd_code_q;
    res_o.cell_color   = rd_color_q;
  end

  always_comb begin
    state_d    = state_q;
    wscr_d     = wscr_q;
    cur_scr_d  = cur_scr_q;
    ptr_d      = ptr_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    req_d      = req_q;
    after_nl_d = after_nl_q;
    clr_mode_d = clr_mode_q;
    rd_code_d  = rd_code_q;
    rd_color_d = rd_color_q;

    areq_o.scr    = wscr_q;
    areq_o.row    = row;
    areq_o.col    = col;
    areq_o.off    = ptr_q;
    areq_o.use_rc = 1'b0;
    mop_o.we      = 1'b0;
    mop_o.wdata   = make_cell(BLANK_CODE, wscr_q, color0_i, color1_i);

    case (state_q)
      ST_INIT: begin
        mop_o.we    = 1'b1;
        mop_o.wdata = '0;
        if (ptr_q == PTR_LAST) begin
          ptr_d = '0;
          if (wscr_q == SCR_LAST) begin
            wscr_d  = '0;
            state_d = ST_IDLE;
          end else begin
            wscr_d = wscr_q + SCR_W'(1);
          end
        end else begin
          ptr_d = ptr_q + OFF_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d      = in_item_i;
          wscr_d     = cur_scr_q;
          rd_code_d  = '0;
          rd_color_d = '0;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (req_q.req_type)
          REQ_PRINT: begin
            if (req_q.char_code == NEWLINE_CODE) begin
              after_nl_d = 1'b0;
              state_d    = ST_NL;
            end else if (col >= COL_W'(COLUMNS)) begin
              after_nl_d = 1'b1;
              state_d    = ST_NL;
            end else begin
              state_d = ST_WR_CHAR;
            end
          end
          REQ_DELETE: begin
            if (col == '0) begin
              if (row != '0) begin
                cur_row_d[wscr_q] = row - ROW_W'(1);
                cur_col_d[wscr_q] = COL_W'(COLUMNS - 1);
              end
            end else begin
              cur_col_d[wscr_q] = col - COL_W'(1);
            end
            state_d = ST_DEL_WR;
          end
          REQ_CLEAR: begin
            if (sel_ok) begin
              wscr_d     = SCR_W'(req_q.screen_sel);
              ptr_d      = '0;
              clr_mode_d = 1'b1;
              state_d    = ST_BLANK;
            end else begin
              state_d = ST_DONE;
            end
          end
          REQ_SWITCH: begin
            if (sel_ok) begin
              cur_scr_d = SCR_W'(req_q.screen_sel);
              wscr_d    = SCR_W'(req_q.screen_sel);
            end
            state_d = ST_DONE;
          end
          REQ_READ: begin
            if (idx32 < 32'(CELLS)) begin
              areq_o.off = idx32[OFF_W-1:0];
              state_d    = ST_RD_WAIT;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_NL: begin
        cur_col_d[wscr_q] = '0;
        if (row < ROW_W'(ROWS - 1)) begin
          cur_row_d[wscr_q] = row + ROW_W'(1);
          state_d = after_nl_q ? ST_WR_CHAR : ST_DONE;
        end else begin
          ptr_d   = '0;
          state_d = ST_SC_RD;
        end
      end
      ST_SC_RD: begin
        areq_o.off = ptr_q + OFF_W'(COLUMNS);
        state_d    = ST_SC_WR;
      end
      ST_SC_WR: begin
        mop_o.we    = 1'b1;
        mop_o.wdata = rdata_i;
        ptr_d       = ptr_q + OFF_W'(1);
        if (ptr_q == SCROLL_END) begin
          clr_mode_d = 1'b0;
          state_d    = ST_BLANK;
        end else begin
          state_d = ST_SC_RD;
        end
      end
      ST_BLANK: begin
        mop_o.we = 1'b1;
        if (ptr_q == PTR_LAST) begin
          if (clr_mode_q) begin
            cur_col_d[wscr_q] = '0;
            cur_row_d[wscr_q] = '0;
            wscr_d  = cur_scr_q;
            state_d = ST_DONE;
          end else begin
            state_d = after_nl_q ? ST_WR_CHAR : ST_DONE;
          end
        end else begin
          ptr_d = ptr_q + OFF_W'(1);
        end
      end
      ST_WR_CHAR: begin
        areq_o.use_rc     = 1'b1;
        mop_o.we          = 1'b1;
        mop_o.wdata       = make_cell(req_q.char_code, wscr_q, color0_i, color1_i);
        cur_col_d[wscr_q] = col + COL_W'(1);
        state_d           = ST_DONE;
      end
      ST_DEL_WR: begin
        areq_o.use_rc = 1'b1;
        mop_o.we      = 1'b1;
        state_d       = ST_DONE;
      end
      ST_RD_WAIT: begin
        rd_code_d  = rdata_i[7:0];
        rd_color_d = rdata_i[15:8];
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      wscr_q    <= '0;
      cur_scr_q <= '0;
      ptr_q     <= '0;
      for (int i = 0; i < NUM_SCREENS; i++) begin
        cur_col_q[i] <= '0;
        cur_row_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      wscr_q    <= wscr_d;
      cur_scr_q <= cur_scr_d;
      ptr_q     <= ptr_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    after_nl_q <= after_nl_d;
    clr_mode_q <= clr_mode_d;
    rd_code_q  <= rd_code_d;
    rd_color_q <= rd_color_d;
  end

endmodule

`default_nettype wire

[rtl/tcce_checker.sv]
`default_nettype none

`include "text_console_cursor_engine_defines.svh"

module tcce_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tcce_pkg::out_item_t out_item_o
);

  import tcce_pkg::*;

  `TCCE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped")
  `TCCE_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_item_o), "result moved")
  `TCCE_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second beat taken early")
  `TCCE_ASSERT_NOW(a_cursor_rng, out_valid_o, out_item_o.cursor_index <= 11'(CELLS), "bad cursor")

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (.*);

`default_nettype wire
